// File: design/jpat_pkg.sv
`timescale 1ns / 1ps
// Package for the per-joint PID controller with integral clamp and safety trip.
// Holds default parameters, field widths, reset values of the settings, action
// and register codes and the sequencer state type. Depends on nothing.
package jpat_pkg;

	// Default values of the top-level parameters
	localparam int NUM_JOINTS_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed widths of the channel fields
	localparam int DATA_W    = 32;
	localparam int LIMIT_W   = 31;
	localparam int JOINT_W   = 3;
	localparam int ACTION_W  = 2;
	localparam int CFG_IDX_W = 3;

	// Reset values of the settings registers
	localparam logic [DATA_W-1:0]  RST_GAIN_P        = 32'd655360;
	localparam logic [DATA_W-1:0]  RST_GAIN_I        = 32'd0;
	localparam logic [DATA_W-1:0]  RST_GAIN_D        = 32'd65536;
	localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT   = 31'd65536;
	localparam logic [LIMIT_W-1:0] RST_MAX_POS_ERR   = 31'd32768;
	localparam logic [DATA_W-1:0]  RST_CTRL_INTERVAL = 32'd655;

	// Action codes of an input word
	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE  = 2'd0,
		ACT_ENABLE  = 2'd1,
		ACT_DISABLE = 2'd2
	} action_t;

	// Settings register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_INTEG_LIMIT   = 3'd3,
		REG_MAX_POS_ERR   = 3'd4,
		REG_CTRL_INTERVAL = 3'd5
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_ERR,
		S_MUL_E,
		S_INTEG,
		S_DIV,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_SUM,
		S_DONE
	} state_t;

endpackage

// File: design/jpat_cfg_if.sv
`timescale 1ns / 1ps
// Settings write channel: register index and write data with valid/ready.
// Depends on jpat_pkg for the field widths.
interface jpat_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [jpat_pkg::CFG_IDX_W-1:0]     index;
	logic [jpat_pkg::DATA_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/jpat_item_if.sv
`timescale 1ns / 1ps
// Input channel: one joint sample or enable/disable word with valid/ready.
// Depends on jpat_pkg for the field widths.
interface jpat_item_if;
	logic                               valid;
	logic                               ready;
	logic [jpat_pkg::ACTION_W-1:0]      action;
	logic [jpat_pkg::JOINT_W-1:0]       joint;
	logic signed [jpat_pkg::DATA_W-1:0] target_position;
	logic signed [jpat_pkg::DATA_W-1:0] target_velocity;
	logic signed [jpat_pkg::DATA_W-1:0] measured_position;
	logic [jpat_pkg::DATA_W-1:0]        elapsed_time;

	modport source (output valid, action, joint, target_position, target_velocity,
		measured_position, elapsed_time, input ready);
	modport sink   (input valid, action, joint, target_position, target_velocity,
		measured_position, elapsed_time, output ready);
endinterface

// File: design/jpat_result_if.sv
`timescale 1ns / 1ps
// Result channel: joint index, drive command and fault flag with valid/ready.
// Depends on jpat_pkg for the field widths.
interface jpat_result_if;
	logic                               valid;
	logic                               ready;
	logic [jpat_pkg::JOINT_W-1:0]       joint_out;
	logic signed [jpat_pkg::DATA_W-1:0] command;
	logic                               fault;

	modport source (output valid, joint_out, command, fault, input ready);
	modport sink   (input valid, joint_out, command, fault, output ready);
endinterface

// File: design/joint_pid_antiwindup_trip_top.sv
`timescale 1ns / 1ps
// Per-joint PID position controller with integral clamp and position-error trip.
// Single sequencer around one shared multiplier and a restoring divider.
// Depends on jpat_pkg and the jpat_cfg_if, jpat_item_if and jpat_result_if interfaces.
//
// Usage
// - cfg: settings writes (index 0 gain_p .. 5 control_interval), always ready.
//   Write settings only while the block has no word in flight.
// - item: one word per joint sample, or an enable/disable word that clears the
//   integral and last-error stores. Ready only while the sequencer is idle.
// - result: one word per applied sample, or a fault word on a position-error
//   trip, which also disables the block and clears all stores.
// Sequence
// - An applied sample steps through check, error, elapsed-time product, integral,
//   divider, the three gain products, sum and done. The restoring divider for
//   the derivative gives one quotient bit per cycle. No new word is taken until
//   the result is loaded; the next can be taken in the cycle after.
// - A trip goes from the error step straight to its result; ignored, enable and
//   disable words free the block after the check. Zero elapsed time skips the divider.
// Reset clears the settings to their defaults, disables the block and marks all
// joint stores as zero. A stalled receiver holds the result register; the block
// takes further words meanwhile until one has a result, and then waits with it.
module joint_pid_antiwindup_trip_top #(
	parameter int NUM_JOINTS = jpat_pkg::NUM_JOINTS_DEF,
	parameter int FRAC_BITS  = jpat_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	jpat_cfg_if.sink      cfg,
	jpat_item_if.sink     item,
	jpat_result_if.source result
);

	localparam int DW_  = jpat_pkg::DATA_W;
	localparam int LW   = jpat_pkg::LIMIT_W;
	localparam int JW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int XW   = (JW > jpat_pkg::JOINT_W) ? JW : jpat_pkg::JOINT_W;
	localparam int PW   = 2 * DW_ + 1;          // gain/time times signed value
	localparam int TW   = PW - FRAC_BITS;       // product after the fraction shift
	localparam int IW   = TW + 1;               // integral sum
	localparam int AW   = TW + 2;               // command accumulator
	localparam int QW   = DW_ + FRAC_BITS;      // divider dividend and quotient
	localparam int CW   = $clog2(QW);

	localparam logic signed [AW-1:0] SAT_MAX = AW'($signed(32'h7FFF_FFFF));
	localparam logic signed [AW-1:0] SAT_MIN = AW'($signed(32'h8000_0000));

	// Settings registers
	logic [DW_-1:0] gain_p_q, gain_i_q, gain_d_q, ctrl_int_q;
	logic [LW-1:0]  int_lim_q, max_err_q;

	// Sequencer
	jpat_pkg::state_t state_q, state_d;
	logic             item_ready, load_out, store_we, clear_all;

	// Captured input word
	logic [jpat_pkg::ACTION_W-1:0] act_q;
	logic [jpat_pkg::JOINT_W-1:0]  joint_q;
	logic signed [DW_-1:0]         tpos_q, tvel_q, mpos_q;
	logic [DW_-1:0]                elap_q;

	// Joint stores
	logic                  enabled_q;
	logic [NUM_JOINTS-1:0] valid_q;
	logic signed [DW_-1:0] integ_mem [NUM_JOINTS];
	logic signed [DW_-1:0] prev_mem  [NUM_JOINTS];
	logic signed [DW_-1:0] int_rd_q, prev_rd_q;
	logic                  ent_vld_q;

	// Datapath registers
	logic signed [DW_:0]   err_q;
	logic                  trip_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [DW_-1:0] integ_q, deriv_q;
	logic [DW_-1:0]        rem_q;
	logic [QW-1:0]         quo_q;
	logic                  dneg_q;
	logic [CW-1:0]         cnt_q;
	logic signed [AW-1:0]  acc_q;

	// Result register
	logic                         out_valid_q, out_fault_q;
	logic [jpat_pkg::JOINT_W-1:0] out_joint_q;
	logic signed [DW_-1:0]        out_cmd_q;

	// Combinational datapath signals
	logic [XW-1:0]         joint_x;
	logic [JW-1:0]         jidx;
	logic                  joint_ok, too_soon, apply_c, trip_c;
	logic signed [DW_:0]   err_c, err_mag;
	logic [DW_-1:0]        mul_a;
	logic signed [DW_-1:0] mul_b;
	logic signed [PW-1:0]  prod_c;
	logic signed [TW-1:0]  term_c;
	logic signed [DW_-1:0] int_old, prev_old, integ_new, deriv_c, cmd_c;
	logic signed [IW-1:0]  integ_sum, lim_pos, lim_neg;
	logic signed [DW_+1:0] diff_c, diff_mag;
	logic [DW_:0]          rem_sh;
	logic [DW_+1:0]        trial;
	logic                  qbit;

	// Joint index and sample qualification
	assign joint_x  = XW'(joint_q);
	assign jidx     = joint_x[JW-1:0];
	assign joint_ok = (32'(joint_q) < 32'(NUM_JOINTS));
	assign too_soon = ({elap_q, 1'b0} < {1'b0, ctrl_int_q});
	assign apply_c  = (act_q == jpat_pkg::ACT_SAMPLE) && enabled_q && !too_soon && joint_ok;

	// Position error and trip compare
	assign err_c   = $signed({tpos_q[DW_-1], tpos_q}) - $signed({mpos_q[DW_-1], mpos_q});
	assign err_mag = err_q[DW_] ? -err_q : err_q;
	assign trip_c  = ($unsigned(err_mag) > {2'b00, max_err_q});

	// Shared multiplier: unsigned gain or time against a signed value
	always_comb begin
		case (state_q)
			jpat_pkg::S_MUL_E: begin
				mul_a = elap_q;
				mul_b = err_q[DW_-1:0];
			end
			jpat_pkg::S_MUL_P: begin
				mul_a = gain_p_q;
				mul_b = err_q[DW_-1:0];
			end
			jpat_pkg::S_MUL_I: begin
				mul_a = gain_i_q;
				mul_b = integ_q;
			end
			jpat_pkg::S_MUL_D: begin
				mul_a = gain_d_q;
				mul_b = deriv_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod_c = $signed({1'b0, mul_a}) * mul_b;
	// Arithmetic shift gives the floor of the scaled product
	assign term_c = TW'(prod_q >>> FRAC_BITS);

	// Stored values; an entry not written since the last clear reads as zero
	assign int_old  = ent_vld_q ? int_rd_q : '0;
	assign prev_old = ent_vld_q ? prev_rd_q : '0;

	// Integral update with clamp to plus or minus the limit
	assign integ_sum = IW'(int_old) + IW'(term_c);
	assign lim_pos   = $signed(IW'({1'b0, int_lim_q}));
	assign lim_neg   = -lim_pos;
	always_comb begin
		if (integ_sum > lim_pos) begin
			integ_new = DW_'(lim_pos);
		end else if (integ_sum < lim_neg) begin
			integ_new = DW_'(lim_neg);
		end else begin
			integ_new = DW_'(integ_sum);
		end
	end

	// Error change, as sign and magnitude for the divider
	assign diff_c   = (DW_+2)'(err_q) - (DW_+2)'(prev_old);
	assign diff_mag = diff_c[DW_+1] ? -diff_c : diff_c;

	// One restoring division step
	assign rem_sh = {rem_q, quo_q[QW-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, elap_q};
	assign qbit   = !trial[DW_+1];

	// Quotient saturated to the signed 32-bit range
	always_comb begin
		if (dneg_q) begin
			if (quo_q > QW'(33'h0_8000_0000)) begin
				deriv_c = $signed(32'h8000_0000);
			end else begin
				deriv_c = DW_'(-quo_q);
			end
		end else begin
			if (quo_q > QW'(32'h7FFF_FFFF)) begin
				deriv_c = $signed(32'h7FFF_FFFF);
			end else begin
				deriv_c = $signed(quo_q[DW_-1:0]);
			end
		end
	end

	// Command saturation
	always_comb begin
		if (acc_q > SAT_MAX) begin
			cmd_c = DW_'(SAT_MAX);
		end else if (acc_q < SAT_MIN) begin
			cmd_c = DW_'(SAT_MIN);
		end else begin
			cmd_c = DW_'(acc_q);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			jpat_pkg::S_IDLE: begin
				if (item.valid) begin
					state_d = jpat_pkg::S_CHECK;
				end
			end
			jpat_pkg::S_CHECK: begin
				state_d = apply_c ? jpat_pkg::S_ERR : jpat_pkg::S_IDLE;
			end
			jpat_pkg::S_ERR: begin
				state_d = trip_c ? jpat_pkg::S_DONE : jpat_pkg::S_MUL_E;
			end
			jpat_pkg::S_MUL_E: begin
				state_d = jpat_pkg::S_INTEG;
			end
			jpat_pkg::S_INTEG: begin
				state_d = (elap_q == '0) ? jpat_pkg::S_MUL_P : jpat_pkg::S_DIV;
			end
			jpat_pkg::S_DIV: begin
				if (cnt_q == CW'(QW - 1)) begin
					state_d = jpat_pkg::S_MUL_P;
				end
			end
			jpat_pkg::S_MUL_P: begin
				state_d = jpat_pkg::S_MUL_I;
			end
			jpat_pkg::S_MUL_I: begin
				state_d = jpat_pkg::S_MUL_D;
			end
			jpat_pkg::S_MUL_D: begin
				state_d = jpat_pkg::S_SUM;
			end
			jpat_pkg::S_SUM: begin
				state_d = jpat_pkg::S_DONE;
			end
			jpat_pkg::S_DONE: begin
				if (!out_valid_q || result.ready) begin
					state_d = jpat_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = jpat_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		item_ready = 1'b0;
		load_out   = 1'b0;
		store_we   = 1'b0;
		clear_all  = 1'b0;
		case (state_q)
			jpat_pkg::S_IDLE: begin
				item_ready = 1'b1;
			end
			jpat_pkg::S_CHECK: begin
				clear_all = (act_q == jpat_pkg::ACT_ENABLE) ||
					(act_q == jpat_pkg::ACT_DISABLE);
			end
			jpat_pkg::S_ERR: begin
				clear_all = trip_c;
			end
			jpat_pkg::S_INTEG: begin
				store_we = 1'b1;
			end
			jpat_pkg::S_DONE: begin
				load_out = !out_valid_q || result.ready;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	assign item.ready = item_ready;
	assign cfg.ready  = 1'b1;

	// Settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= jpat_pkg::RST_GAIN_P;
			gain_i_q   <= jpat_pkg::RST_GAIN_I;
			gain_d_q   <= jpat_pkg::RST_GAIN_D;
			int_lim_q  <= jpat_pkg::RST_INTEG_LIMIT;
			max_err_q  <= jpat_pkg::RST_MAX_POS_ERR;
			ctrl_int_q <= jpat_pkg::RST_CTRL_INTERVAL;
		end else if (cfg.valid) begin
			case (cfg.index)
				jpat_pkg::REG_GAIN_P:        gain_p_q   <= cfg.data;
				jpat_pkg::REG_GAIN_I:        gain_i_q   <= cfg.data;
				jpat_pkg::REG_GAIN_D:        gain_d_q   <= cfg.data;
				jpat_pkg::REG_INTEG_LIMIT:   int_lim_q  <= cfg.data[LW-1:0];
				jpat_pkg::REG_MAX_POS_ERR:   max_err_q  <= cfg.data[LW-1:0];
				jpat_pkg::REG_CTRL_INTERVAL: ctrl_int_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Control state: sequencer, enable, store valid bits, result valid, divider count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jpat_pkg::S_IDLE;
			enabled_q   <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == jpat_pkg::S_CHECK) begin
				if (act_q == jpat_pkg::ACT_ENABLE) begin
					enabled_q <= 1'b1;
				end else if (act_q == jpat_pkg::ACT_DISABLE) begin
					enabled_q <= 1'b0;
				end
			end
			if (state_q == jpat_pkg::S_ERR && trip_c) begin
				enabled_q <= 1'b0;
			end
			if (clear_all) begin
				valid_q <= '0;
			end else if (store_we) begin
				valid_q[jidx] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == jpat_pkg::S_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Joint stores: one read per accepted word, one write per applied sample
	always_ff @(posedge clk) begin
		if (state_q == jpat_pkg::S_CHECK) begin
			int_rd_q  <= integ_mem[jidx];
			prev_rd_q <= prev_mem[jidx];
			ent_vld_q <= valid_q[jidx];
		end
		if (store_we) begin
			integ_mem[jidx] <= integ_new;
			prev_mem[jidx]  <= err_q[DW_-1:0];
		end
	end

	// Datapath registers, stepped by the sequencer
	always_ff @(posedge clk) begin
		if (item_ready && item.valid) begin
			act_q   <= item.action;
			joint_q <= item.joint;
			tpos_q  <= item.target_position;
			tvel_q  <= item.target_velocity;
			mpos_q  <= item.measured_position;
			elap_q  <= item.elapsed_time;
		end
		case (state_q)
			jpat_pkg::S_CHECK: begin
				err_q <= err_c;
			end
			jpat_pkg::S_ERR: begin
				trip_q <= trip_c;
			end
			jpat_pkg::S_MUL_E: begin
				prod_q <= prod_c;
			end
			jpat_pkg::S_INTEG: begin
				integ_q <= integ_new;
				dneg_q  <= diff_c[DW_+1];
				rem_q   <= '0;
				if (elap_q == '0) begin
					quo_q <= '0;
				end else begin
					quo_q <= {diff_mag[DW_-1:0], {FRAC_BITS{1'b0}}};
				end
			end
			jpat_pkg::S_DIV: begin
				rem_q <= qbit ? trial[DW_-1:0] : rem_sh[DW_-1:0];
				quo_q <= {quo_q[QW-2:0], qbit};
			end
			jpat_pkg::S_MUL_P: begin
				prod_q  <= prod_c;
				deriv_q <= deriv_c;
				acc_q   <= AW'(tvel_q);
			end
			jpat_pkg::S_MUL_I, jpat_pkg::S_MUL_D: begin
				prod_q <= prod_c;
				acc_q  <= acc_q + AW'(term_c);
			end
			jpat_pkg::S_SUM: begin
				acc_q <= acc_q + AW'(term_c);
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_joint_q <= joint_q;
			out_fault_q <= trip_q;
			out_cmd_q   <= trip_q ? '0 : cmd_c;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.joint_out = out_joint_q;
	assign result.command   = out_cmd_q;
	assign result.fault     = out_fault_q;

`ifndef ASSERT_OFF
	// A fault word never carries a drive value
	a_fault_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.fault |-> result.command == '0)
		else $error("fault result with nonzero command");

	// A trip disables the block and clears every store
	a_trip_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jpat_pkg::S_ERR && trip_c |=> !enabled_q && valid_q == '0)
		else $error("trip did not disable and clear");

	// An enable word enables the block with empty stores
	a_enable_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jpat_pkg::S_CHECK && act_q == jpat_pkg::ACT_ENABLE |=>
		enabled_q && valid_q == '0)
		else $error("enable did not clear stores");

	// The divider stops after the last quotient bit
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jpat_pkg::S_DIV |-> cnt_q <= CW'(QW - 1))
		else $error("divider step count overrun");

	// A finished result waits while the result register is still held
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jpat_pkg::S_DONE && out_valid_q && !result.ready |=>
		state_q == jpat_pkg::S_DONE)
		else $error("result register overwritten while stalled");
`endif

endmodule

// File: sim/tb_joint_pid_antiwindup_trip_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the per-joint PID controller with integral clamp and trip.
// Depends on jpat_pkg, the three channel interfaces and joint_pid_antiwindup_trip_top.
module tb_joint_pid_antiwindup_trip_top;

	localparam int NUM_J         = jpat_pkg::NUM_JOINTS_DEF;
	localparam int FRAC          = jpat_pkg::FRAC_BITS_DEF;
	localparam int IDLE_PCT      = 19;
	localparam int RESET_CYCLES  = 10;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 70;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_WORDS   = 78;
	localparam int RANDOM_PHASES = 6;
	localparam int MAX_REPORTS   = 40;
	localparam longint U32_MAX   = 64'h0000_0000_FFFF_FFFF;

	// The action field can carry a fourth code that the block must ignore.
	localparam logic [jpat_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;

	typedef struct packed {
		logic [jpat_pkg::ACTION_W-1:0]      action;
		logic [jpat_pkg::JOINT_W-1:0]       joint;
		logic signed [jpat_pkg::DATA_W-1:0] target_position;
		logic signed [jpat_pkg::DATA_W-1:0] target_velocity;
		logic signed [jpat_pkg::DATA_W-1:0] measured_position;
		logic [jpat_pkg::DATA_W-1:0]        elapsed_time;
	} joint_word_t;

	typedef struct packed {
		logic [jpat_pkg::JOINT_W-1:0]       joint;
		logic signed [jpat_pkg::DATA_W-1:0] command;
		logic                               fault;
	} drive_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jpat_cfg_if    cfg_bus();
	jpat_item_if   word_bus();
	jpat_result_if result_bus();

	joint_pid_antiwindup_trip_top #(
		.NUM_JOINTS(NUM_J),
		.FRAC_BITS (FRAC)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.item  (word_bus),
		.result(result_bus)
	);

	// Shadow copy of the settings, starting from their reset values.
	logic [jpat_pkg::DATA_W-1:0]  kp           = jpat_pkg::RST_GAIN_P;
	logic [jpat_pkg::DATA_W-1:0]  ki           = jpat_pkg::RST_GAIN_I;
	logic [jpat_pkg::DATA_W-1:0]  kd           = jpat_pkg::RST_GAIN_D;
	logic [jpat_pkg::LIMIT_W-1:0] integ_clamp  = jpat_pkg::RST_INTEG_LIMIT;
	logic [jpat_pkg::LIMIT_W-1:0] trip_level   = jpat_pkg::RST_MAX_POS_ERR;
	logic [jpat_pkg::DATA_W-1:0]  min_interval = jpat_pkg::RST_CTRL_INTERVAL;

	// Shadow copy of the per-joint stores and the enable flag.
	logic signed [jpat_pkg::DATA_W-1:0] integ_acc [NUM_J];
	logic signed [jpat_pkg::DATA_W-1:0] last_err [NUM_J];
	logic ctl_enabled = 1'b0;

	drive_result_t pending_commands [$];

	bit steady = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int words_sent = 0;
	int words_effective = 0;
	int settings_loads = 0;
	int samples_applied = 0;
	int trips_predicted = 0;
	int results_seen = 0;
	int error_count = 0;

	always #10 clk = ~clk;

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ERROR: %s", $time, msg);
	endfunction

	function automatic void check_field(input string name,
			input logic signed [jpat_pkg::DATA_W-1:0] want,
			input logic signed [jpat_pkg::DATA_W-1:0] got);
		if (got !== want)
			report_error($sformatf("%s expected %0d, got %0d", name, want, got));
	endfunction

	function automatic longint clip_s32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic void clear_joint_stores();
		for (int j = 0; j < NUM_J; j++) begin
			integ_acc[j] = '0;
			last_err[j]  = '0;
		end
	endfunction

	// Advance the shadow controller by one accepted word and queue the command it
	// produces. Returns 0 when the block simply ignores the word.
	function automatic bit apply_word(input joint_word_t w);
		longint tp, mp, tv, err, mag, el, ivl, lim, integ, prev, deriv, cmd, gp, gi, gd;
		int j;
		j = w.joint;
		if (w.action == jpat_pkg::ACT_ENABLE || w.action == jpat_pkg::ACT_DISABLE) begin
			ctl_enabled = (w.action == jpat_pkg::ACT_ENABLE);
			clear_joint_stores();
			return 1'b1;
		end
		el  = w.elapsed_time;
		ivl = min_interval;
		if (w.action != jpat_pkg::ACT_SAMPLE || !ctl_enabled || 2 * el < ivl || j >= NUM_J)
			return 1'b0;

		tp  = $signed(w.target_position);
		mp  = $signed(w.measured_position);
		err = tp - mp;
		mag = (err < 0) ? -err : err;
		lim = trip_level;

		// Safety trip: fault word, block disabled, every store cleared.
		if (mag > lim) begin
			ctl_enabled = 1'b0;
			clear_joint_stores();
			pending_commands.push_back('{joint: w.joint, command: '0, fault: 1'b1});
			trips_predicted++;
			return 1'b1;
		end

		// Integral of error times elapsed time, clamped both ways.
		lim   = integ_clamp;
		prev  = integ_acc[j];
		integ = prev + ((err * el) >>> FRAC);
		if (integ > lim)
			integ = lim;
		else if (integ < -lim)
			integ = -lim;
		integ_acc[j] = integ[jpat_pkg::DATA_W-1:0];

		// Derivative of the error, truncated towards zero and saturated.
		prev = last_err[j];
		deriv = (el == 0) ? 0 : clip_s32(((err - prev) <<< FRAC) / el);
		last_err[j] = err[jpat_pkg::DATA_W-1:0];

		gp = kp;
		gi = ki;
		gd = kd;
		tv = $signed(w.target_velocity);
		cmd = clip_s32(((gp * err) >>> FRAC) + ((gi * integ) >>> FRAC)
			+ ((gd * deriv) >>> FRAC) + tv);
		pending_commands.push_back('{joint: w.joint, command: cmd[jpat_pkg::DATA_W-1:0],
			fault: 1'b0});
		samples_applied++;
		return 1'b1;
	endfunction

	function automatic joint_word_t mk_word(input logic [jpat_pkg::ACTION_W-1:0] act,
			input logic [jpat_pkg::JOINT_W-1:0] jnt,
			input logic signed [jpat_pkg::DATA_W-1:0] tpos,
			input logic signed [jpat_pkg::DATA_W-1:0] tvel,
			input logic signed [jpat_pkg::DATA_W-1:0] mpos,
			input logic [jpat_pkg::DATA_W-1:0] el);
		joint_word_t w;
		w.action            = act;
		w.joint             = jnt;
		w.target_position   = tpos;
		w.target_velocity   = tvel;
		w.measured_position = mpos;
		w.elapsed_time      = el;
		return w;
	endfunction

	function automatic logic [jpat_pkg::DATA_W-1:0] rand_gain();
		return ($urandom_range(99) < 70) ? $urandom_range(0, 32'h0010_0000) : $urandom;
	endfunction

	// Mostly well-formed samples with errors inside the trip level and steps long
	// enough to be applied; the rest are trips, early samples and other actions.
	function automatic joint_word_t gen_random_word();
		joint_word_t w;
		int unsigned pick;
		longint mag, span, half, el, low, lvl;
		w = mk_word(jpat_pkg::ACT_SAMPLE, $urandom_range(NUM_J - 1), $urandom,
			$signed($urandom) >>> $urandom_range(31), $urandom, $urandom);
		pick = $urandom_range(99);
		if (pick < 4 || (!ctl_enabled && pick < 80)) begin
			w.action = jpat_pkg::ACT_ENABLE;
			return w;
		end
		if (pick < 8) begin
			w.action = jpat_pkg::ACT_DISABLE;
			return w;
		end
		if (pick < 11) begin
			w.action = ACT_RESERVED;
			return w;
		end

		// Elapsed time around the lower bound of an accepted step.
		half = min_interval;
		half = (half + 1) / 2;
		pick = $urandom_range(99);
		if (pick < 6) begin
			el = $urandom_range(0, half - 1);
		end else if (pick < 12) begin
			el = $urandom;
		end else begin
			el = half + ($urandom >> $urandom_range(31));
			if (el > U32_MAX)
				el = U32_MAX;
		end
		w.elapsed_time = el[jpat_pkg::DATA_W-1:0];

		// Error magnitude: beyond the trip level, right on it, or spread below it.
		lvl  = trip_level;
		pick = $urandom_range(99);
		if (pick < 5) begin
			mag = lvl + 1 + ($urandom_range(0, U32_MAX - lvl - 1) >> $urandom_range(31));
		end else if (pick < 9) begin
			mag = lvl;
		end else begin
			mag = $urandom >> $urandom_range(31);
			if (mag > lvl)
				mag = mag % (lvl + 1);
		end

		// Place the pair of positions anywhere the difference still fits.
		span = U32_MAX - mag;
		low  = longint'($urandom_range(0, span)) - 64'sd2147483648;
		if ($urandom_range(1)) begin
			w.target_position   = low + mag;
			w.measured_position = low;
		end else begin
			w.target_position   = low;
			w.measured_position = low + mag;
		end
		return w;
	endfunction

	// Offer one input word, with a random gap first, and wait for its acceptance.
	task automatic send_word(input joint_word_t w);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			word_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		word_bus.valid             <= 1'b1;
		word_bus.action            <= w.action;
		word_bus.joint             <= w.joint;
		word_bus.target_position   <= w.target_position;
		word_bus.target_velocity   <= w.target_velocity;
		word_bus.measured_position <= w.measured_position;
		word_bus.elapsed_time      <= w.elapsed_time;
		@(posedge clk);
		while (!word_bus.ready)
			@(posedge clk);
		words_sent++;
		if (apply_word(w))
			words_effective++;
	endtask

	task automatic write_reg(input jpat_pkg::reg_idx_t idx,
			input logic [jpat_pkg::DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			jpat_pkg::REG_GAIN_P:        kp = value;
			jpat_pkg::REG_GAIN_I:        ki = value;
			jpat_pkg::REG_GAIN_D:        kd = value;
			jpat_pkg::REG_INTEG_LIMIT:   integ_clamp = value[jpat_pkg::LIMIT_W-1:0];
			jpat_pkg::REG_MAX_POS_ERR:   trip_level = value[jpat_pkg::LIMIT_W-1:0];
			jpat_pkg::REG_CTRL_INTERVAL: min_interval = value;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [jpat_pkg::DATA_W-1:0] p,
			input logic [jpat_pkg::DATA_W-1:0] i, input logic [jpat_pkg::DATA_W-1:0] d,
			input logic [jpat_pkg::LIMIT_W-1:0] lim, input logic [jpat_pkg::LIMIT_W-1:0] trip,
			input logic [jpat_pkg::DATA_W-1:0] ivl);
		write_reg(jpat_pkg::REG_GAIN_P, p);
		write_reg(jpat_pkg::REG_GAIN_I, i);
		write_reg(jpat_pkg::REG_GAIN_D, d);
		write_reg(jpat_pkg::REG_INTEG_LIMIT, {1'b0, lim});
		write_reg(jpat_pkg::REG_MAX_POS_ERR, {1'b0, trip});
		write_reg(jpat_pkg::REG_CTRL_INTERVAL, ivl);
		cfg_bus.valid <= 1'b0;
		settings_loads++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_commands.size() != 0);
	endtask

	// Stop offering words, collect every expected command and let any ignored
	// word still in the block run out before the settings change.
	task automatic settle_block();
		word_bus.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reset values: disabled words, the early-step boundary, the reserved action
	// and a trip on the last joint.
	task automatic test_default_settings();
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd0, 32'sd1000, 32'sd0, 32'sd0, 32'd655));
		send_word(mk_word(ACT_RESERVED, 3'd5, 32'sd7, 32'sd7, 32'sd7, 32'd7));
		send_word(mk_word(jpat_pkg::ACT_ENABLE, 3'd0, 32'sd0, 32'sd0, 32'sd0, 32'd0));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd0, 32'sd16384, 32'sd300, 32'sd0, 32'd655));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd0, 32'sd100, 32'sd0, 32'sd0, 32'd327));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd0, 32'sd0, -32'sd5, 32'sd32768, 32'd328));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd7, 32'sd32769, 32'sd0, 32'sd0, 32'd700));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd7, 32'sd1, 32'sd0, 32'sd0, 32'd700));
	endtask

	// Largest gains, limits and positions, the smallest interval, saturation of
	// the derivative and of the command both ways.
	task automatic test_extreme_settings();
		settle_block();
		load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 32'd1);
		send_word(mk_word(jpat_pkg::ACT_ENABLE, 3'd0, 32'sd0, 32'sd0, 32'sd0, 32'd0));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sd0,
			32'hFFFF_FFFF));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd7, 32'h8000_0001, 32'h8000_0000, 32'sd0,
			32'd1));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd0, 32'h8000_0000, 32'sd0, 32'h8000_0000,
			32'd1));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd3, 32'sd5, 32'sd0, 32'sd0, 32'd0));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd2, 32'h8000_0000, 32'sd0, 32'sd0, 32'd4));
		send_word(mk_word(ACT_RESERVED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_word(mk_word(jpat_pkg::ACT_DISABLE, 3'd7, 32'sd0, 32'sd0, 32'sd0, 32'd0));
	endtask

	// Zero gains and clamp, the tightest trip level and the longest interval.
	task automatic test_minimum_settings();
		settle_block();
		load_settings(32'd0, 32'd0, 32'd0, 31'd0, 31'd1, 32'hFFFF_FFFF);
		send_word(mk_word(jpat_pkg::ACT_ENABLE, 3'd4, 32'sd0, 32'sd0, 32'sd0, 32'd0));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd4, 32'sd1, $urandom, 32'sd0,
			32'h8000_0000));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd4, 32'sd1, 32'sd9, 32'sd0, 32'h7FFF_FFFF));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd1, 32'sd0, -32'sd77, 32'sd1,
			32'hFFFF_FFFF));
		send_word(mk_word(jpat_pkg::ACT_SAMPLE, 3'd1, 32'sd5, 32'sd0, 32'sd3, 32'hFFFF_FFFF));
	endtask

	// Result side held off while words keep coming, then a pause on the input
	// side until every command is back.
	task automatic test_flow_control();
		int k;
		settle_block();
		load_settings(32'h000A_0000, 32'h0002_0000, 32'h0000_8000, 31'h0001_0000,
			31'h0004_0000, 32'd655);
		send_word(mk_word(jpat_pkg::ACT_ENABLE, 3'd0, 32'sd0, 32'sd0, 32'sd0, 32'd0));
		hold_request = HOLD_CYCLES;
		for (k = 0; k < 8; k++)
			send_word(gen_random_word());
		word_bus.valid <= 1'b0;
		wait_drained();
		for (k = 0; k < 10; k++)
			send_word(gen_random_word());
	endtask

	// Random phases, each under fresh random settings; one phase runs with no
	// idling on either side.
	task automatic test_random_phases();
		int ph;
		int goal;
		int unsigned pick;
		logic [jpat_pkg::DATA_W-1:0] ivl;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle_block();
			pick = $urandom_range(99);
			ivl = (pick < 50) ? $urandom_range(1, 2000) :
				(pick < 80) ? $urandom_range(1, 32'h0010_0000) :
				$urandom_range(1, 32'hFFFF_FFFF);
			load_settings(rand_gain(), rand_gain(), rand_gain(),
				$urandom_range(1) ? $urandom_range(0, 32'h0004_0000) : $urandom,
				($urandom_range(99) < 60) ? $urandom_range(1, 32'h0008_0000) :
				$urandom_range(1, 32'h7FFF_FFFF),
				ivl);
			steady = (ph == 2);
			goal = words_effective + PHASE_WORDS;
			while (words_effective < goal)
				send_word(gen_random_word());
		end
		steady = 1'b0;
	endtask

	// Result side: check each accepted word against the oldest expected command,
	// then decide readiness for the next edge.
	always @(posedge clk) begin : result_side
		drive_result_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (pending_commands.size() == 0) begin
					report_error($sformatf("unexpected result word: joint %0d command %0d fault %0b",
						result_bus.joint_out, result_bus.command, result_bus.fault));
				end else begin
					want = pending_commands.pop_front();
					check_field("joint_out", want.joint, result_bus.joint_out);
					check_field("command", want.command, result_bus.command);
					check_field("fault", want.fault, result_bus.fault);
				end
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: ends the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (word_bus.valid && word_bus.ready) ||
				(result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ERROR: no word moved for %0d cycles, %0d commands outstanding",
					$time, quiet_cycles, pending_commands.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		cfg_bus.valid              = 1'b0;
		cfg_bus.index              = jpat_pkg::REG_GAIN_P;
		cfg_bus.data               = '0;
		word_bus.valid             = 1'b0;
		word_bus.action            = jpat_pkg::ACT_SAMPLE;
		word_bus.joint             = '0;
		word_bus.target_position   = '0;
		word_bus.target_velocity   = '0;
		word_bus.measured_position = '0;
		word_bus.elapsed_time      = '0;
		result_bus.ready           = 1'b0;
		clear_joint_stores();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_default_settings();
		test_extreme_settings();
		test_minimum_settings();
		test_flow_control();
		test_random_phases();
		settle_block();

		$display("Run covered %0d input words (%0d acted on) under %0d settings loads.",
			words_sent, words_effective, settings_loads);
		$display("It predicted %0d commands and %0d safety trips; %0d result words checked.",
			samples_applied, trips_predicted, results_seen);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
